// File: rtl/core/priority_bitmap_task_scheduler_defines.svh
// ----------------------------------------------------------------------------
// Priority bitmap task scheduler: assertion macros
// Checks on the rising edge of clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_BITMAP_TASK_SCHEDULER_DEFINES_SVH
`define PRIORITY_BITMAP_TASK_SCHEDULER_DEFINES_SVH

// Consequent holds in the same cycle as the antecedent.
`define PBTS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler check failed");

// Consequent holds in the cycle after the antecedent.
`define PBTS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler check failed");

`endif

// File: rtl/core/pbts_pkg.sv
// ----------------------------------------------------------------------------
// Priority bitmap task scheduler package
// Command kinds, sequencer states and the queue command and status types.
// ----------------------------------------------------------------------------
`default_nettype none

package pbts_pkg;

    localparam int PRIO_W = 5;
    localparam int MASK_W = 32;
    localparam int PORT_ID_W = 8;

    typedef enum logic [1:0] {
        KIND_ADD   = 2'd0,
        KIND_SCHED = 2'd1,
        KIND_YIELD = 2'd2,
        KIND_SLEEP = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_POP,
        ST_POP_DATA,
        ST_ENQ,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        QOP_NONE,
        QOP_PUSH,
        QOP_POP,
        QOP_CLEAR
    } qop_t;

    typedef struct packed {
        qop_t              op;
        logic [PRIO_W-1:0] prio;
    } qcmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic last;
    } qstat_t;

endpackage

`default_nettype wire

// File: rtl/core/pbts_qptr.sv
// ----------------------------------------------------------------------------
// Priority bitmap task scheduler: queue pointer unit
// Shared ring arithmetic for one level: tail slot, head advance, occupancy.
// ----------------------------------------------------------------------------
`default_nettype none

module pbts_qptr #(
    parameter int DEPTH = 8,
    localparam int QW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  wire logic [QW-1:0] head,
    input  wire logic [CW-1:0] count,
    output pbts_pkg::qstat_t   stat,
    output logic [QW-1:0]      tail,
    output logic [QW-1:0]      head_inc,
    output logic [CW-1:0]      count_inc,
    output logic [CW-1:0]      count_dec
);

    localparam int SW = $clog2(2 * DEPTH);

    logic [SW-1:0] sum;

    assign sum  = SW'(head) + SW'(count);
    assign tail = (sum >= SW'(DEPTH)) ? QW'(sum - SW'(DEPTH)) : QW'(sum);

    assign head_inc  = (head == QW'(DEPTH - 1)) ? '0 : head + QW'(1);
    assign count_inc = count + CW'(1);
    assign count_dec = count - CW'(1);

    assign stat.full  = (count == CW'(DEPTH));
    assign stat.empty = (count == '0);
    assign stat.last  = (count == CW'(1));

endmodule

`default_nettype wire

// File: rtl/core/pbts_queues.sv
// ----------------------------------------------------------------------------
// Priority bitmap task scheduler: queue store
// Per-level ring buffers in one memory, head and count tables, ready bitmap.
// ----------------------------------------------------------------------------
`default_nettype none

module pbts_queues #(
    parameter int NUM_PRIORITIES = 32,
    parameter int QUEUE_DEPTH = 8,
    parameter int ID_W = 8,
    localparam int PIW = (NUM_PRIORITIES > 1) ? $clog2(NUM_PRIORITIES) : 1,
    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
    localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire pbts_pkg::qcmd_t               cmd,
    input  wire logic [ID_W-1:0]               push_id,
    output pbts_pkg::qstat_t                   stat,
    output logic [ID_W-1:0]                    pop_id,
    output logic [pbts_pkg::MASK_W-1:0]        ready
);

    localparam int MEM_DEPTH = NUM_PRIORITIES << QW;

    logic [ID_W-1:0]             store_reg [MEM_DEPTH];
    logic [QW-1:0]               head_reg  [NUM_PRIORITIES];
    logic [CW-1:0]               count_reg [NUM_PRIORITIES];
    logic [pbts_pkg::MASK_W-1:0] ready_reg;
    logic [ID_W-1:0]             pop_id_reg;

    logic [PIW-1:0]              idx;
    logic [pbts_pkg::PRIO_W-1:0] rbit;
    logic [QW-1:0]               tail;
    logic [QW-1:0]               head_inc;
    logic [CW-1:0]               count_inc;
    logic [CW-1:0]               count_dec;
    logic                        do_push;
    logic                        do_pop;

    assign idx  = cmd.prio[PIW-1:0];
    assign rbit = ~cmd.prio;

    pbts_qptr #(
        .DEPTH (QUEUE_DEPTH)
    ) u_qptr (
        .head      (head_reg[idx]),
        .count     (count_reg[idx]),
        .stat      (stat),
        .tail      (tail),
        .head_inc  (head_inc),
        .count_inc (count_inc),
        .count_dec (count_dec)
    );

    assign do_push = (cmd.op == pbts_pkg::QOP_PUSH) && !stat.full;
    assign do_pop  = (cmd.op == pbts_pkg::QOP_POP) && !stat.empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[{idx, tail}] <= push_id;
        end
        if (do_pop)
        begin
            pop_id_reg <= store_reg[{idx, head_reg[idx]}];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '{default: '0};
            count_reg <= '{default: '0};
            ready_reg <= '0;
        end
        else
        begin
            unique case (cmd.op)
                pbts_pkg::QOP_PUSH:
                begin
                    if (!stat.full)
                    begin
                        count_reg[idx]  <= count_inc;
                        ready_reg[rbit] <= 1'b1;
                    end
                end
                pbts_pkg::QOP_POP:
                begin
                    if (!stat.empty)
                    begin
                        head_reg[idx]  <= head_inc;
                        count_reg[idx] <= count_dec;
                        if (stat.last)
                        begin
                            ready_reg[rbit] <= 1'b0;
                        end
                    end
                end
                pbts_pkg::QOP_CLEAR:
                begin
                    ready_reg[rbit] <= 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign pop_id = pop_id_reg;
    assign ready  = ready_reg;

endmodule

`default_nettype wire

// File: rtl/core/priority_bitmap_task_scheduler.sv
// Steps: decode, then done for sleep, empty schedule, out-of-range add and idle yield; enqueue,
// done for add and yield; pop, pop data, done for a schedule that pops, with enqueue before done
// when it also requeues. Results load from done. One item at a time: the next is accepted once
// the result loads and the sequencer is back in idle. It waits in done while the output stalls
// and otherwise walks one queue access per cycle through the shared pointer unit.
// Reset: asynchronous, active low; clears all queues, the ready bitmap and the running task.
// ----------------------------------------------------------------------------
// Priority bitmap task scheduler
// Fixed-priority scheduler with one FIFO per level and a leading-zero search
// over the ready bitmap; add, schedule, yield and sleep commands.
// ----------------------------------------------------------------------------
`default_nettype none

`include "priority_bitmap_task_scheduler_defines.svh"

module priority_bitmap_task_scheduler #(
    parameter int NUM_PRIORITIES = 32,
    parameter int QUEUE_DEPTH = 8,
    parameter int ID_BITS = 8
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            req_valid,
    output logic                                 req_stall,
    input  wire logic [1:0]                      kind,
    input  wire logic [pbts_pkg::PORT_ID_W-1:0]  task_id,
    input  wire logic [pbts_pkg::PRIO_W-1:0]     task_priority,
    output logic                                 rsp_valid,
    input  wire logic                            rsp_stall,
    output logic [pbts_pkg::PORT_ID_W-1:0]       running_task,
    output logic                                 running_valid,
    output logic                                 switched,
    output logic                                 queue_overflow,
    output logic [pbts_pkg::MASK_W-1:0]          ready_mask
);

    localparam int IDW = (ID_BITS < pbts_pkg::PORT_ID_W) ? ID_BITS : pbts_pkg::PORT_ID_W;
    localparam int PW  = pbts_pkg::PRIO_W;

    pbts_pkg::state_t state_reg, state_next;
    pbts_pkg::kind_t  kind_reg, kind_next;
    logic [IDW-1:0]   id_reg, id_next;
    logic [PW-1:0]    prio_reg, prio_next;
    logic [PW-1:0]    sel_reg, sel_next;
    logic [IDW-1:0]   cur_id_reg, cur_id_next;
    logic [PW-1:0]    cur_prio_reg, cur_prio_next;
    logic             cur_valid_reg, cur_valid_next;
    logic             sw_reg, sw_next;
    logic             ovf_reg, ovf_next;

    logic                            rsp_valid_reg, rsp_valid_next;
    logic [pbts_pkg::PORT_ID_W-1:0]  rsp_task_reg;
    logic                            rsp_run_reg;
    logic                            rsp_sw_reg;
    logic                            rsp_ovf_reg;
    logic [pbts_pkg::MASK_W-1:0]     rsp_mask_reg;
    logic                            rsp_load;

    pbts_pkg::qcmd_t              qcmd;
    pbts_pkg::qstat_t             qstat;
    logic [IDW-1:0]               pop_id;
    logic [pbts_pkg::MASK_W-1:0]  ready;

    logic [pbts_pkg::MASK_W-1:0]  lz_x;
    logic [PW-1:0]                lz_n;

    pbts_queues #(
        .NUM_PRIORITIES (NUM_PRIORITIES),
        .QUEUE_DEPTH    (QUEUE_DEPTH),
        .ID_W           (IDW)
    ) u_queues (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (qcmd),
        .push_id (id_reg),
        .stat    (qstat),
        .pop_id  (pop_id),
        .ready   (ready)
    );

    always_comb
    begin
        lz_x = ready;
        lz_n = '0;
        if (lz_x <= 32'h0000FFFF)
        begin
            lz_n = lz_n + PW'(16);
            lz_x = lz_x << 16;
        end
        if (lz_x <= 32'h00FFFFFF)
        begin
            lz_n = lz_n + PW'(8);
            lz_x = lz_x << 8;
        end
        if (lz_x <= 32'h0FFFFFFF)
        begin
            lz_n = lz_n + PW'(4);
            lz_x = lz_x << 4;
        end
        if (lz_x <= 32'h3FFFFFFF)
        begin
            lz_n = lz_n + PW'(2);
            lz_x = lz_x << 2;
        end
        if (lz_x <= 32'h7FFFFFFF)
        begin
            lz_n = lz_n + PW'(1);
        end
    end

    assign req_stall = (state_reg != pbts_pkg::ST_IDLE);
    assign rsp_load  = (state_reg == pbts_pkg::ST_DONE) && (!rsp_valid_reg || !rsp_stall);

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        id_next        = id_reg;
        prio_next      = prio_reg;
        sel_next       = sel_reg;
        cur_id_next    = cur_id_reg;
        cur_prio_next  = cur_prio_reg;
        cur_valid_next = cur_valid_reg;
        sw_next        = sw_reg;
        ovf_next       = ovf_reg;
        qcmd.op        = pbts_pkg::QOP_NONE;
        qcmd.prio      = prio_reg;

        unique case (state_reg)
            pbts_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    kind_next  = pbts_pkg::kind_t'(kind);
                    id_next    = task_id[IDW-1:0];
                    prio_next  = task_priority;
                    sw_next    = 1'b0;
                    ovf_next   = 1'b0;
                    state_next = pbts_pkg::ST_DECODE;
                end
            end
            pbts_pkg::ST_DECODE:
            begin
                unique case (kind_reg)
                    pbts_pkg::KIND_ADD:
                    begin
                        if ({1'b0, prio_reg} < (PW + 1)'(NUM_PRIORITIES))
                        begin
                            state_next = pbts_pkg::ST_ENQ;
                        end
                        else
                        begin
                            state_next = pbts_pkg::ST_DONE;
                        end
                    end
                    pbts_pkg::KIND_SCHED:
                    begin
                        if (ready != '0)
                        begin
                            sel_next   = lz_n;
                            state_next = pbts_pkg::ST_POP;
                        end
                        else
                        begin
                            state_next = pbts_pkg::ST_DONE;
                        end
                    end
                    pbts_pkg::KIND_YIELD:
                    begin
                        if (cur_valid_reg)
                        begin
                            prio_next      = cur_prio_reg;
                            id_next        = cur_id_reg;
                            cur_valid_next = 1'b0;
                            state_next     = pbts_pkg::ST_ENQ;
                        end
                        else
                        begin
                            state_next = pbts_pkg::ST_DONE;
                        end
                    end
                    pbts_pkg::KIND_SLEEP:
                    begin
                        cur_valid_next = 1'b0;
                        state_next     = pbts_pkg::ST_DONE;
                    end
                    default:
                    begin
                        state_next = pbts_pkg::ST_DONE;
                    end
                endcase
            end
            pbts_pkg::ST_POP:
            begin
                qcmd.prio = sel_reg;
                if (({1'b0, sel_reg} >= (PW + 1)'(NUM_PRIORITIES)) || qstat.empty)
                begin
                    qcmd.op    = pbts_pkg::QOP_CLEAR;
                    state_next = pbts_pkg::ST_DONE;
                end
                else
                begin
                    qcmd.op    = pbts_pkg::QOP_POP;
                    state_next = pbts_pkg::ST_POP_DATA;
                end
            end
            pbts_pkg::ST_POP_DATA:
            begin
                if (cur_valid_reg)
                begin
                    prio_next  = cur_prio_reg;
                    id_next    = cur_id_reg;
                    state_next = pbts_pkg::ST_ENQ;
                end
                else
                begin
                    state_next = pbts_pkg::ST_DONE;
                end
                cur_id_next    = pop_id;
                cur_prio_next  = sel_reg;
                cur_valid_next = 1'b1;
                sw_next        = 1'b1;
            end
            pbts_pkg::ST_ENQ:
            begin
                qcmd.op    = pbts_pkg::QOP_PUSH;
                ovf_next   = qstat.full;
                state_next = pbts_pkg::ST_DONE;
            end
            pbts_pkg::ST_DONE:
            begin
                if (rsp_load)
                begin
                    state_next = pbts_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pbts_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_stall)
        begin
            rsp_valid_next = rsp_valid_reg;
        end
        else
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pbts_pkg::ST_IDLE;
            cur_id_reg    <= '0;
            cur_prio_reg  <= '0;
            cur_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_id_reg    <= cur_id_next;
            cur_prio_reg  <= cur_prio_next;
            cur_valid_reg <= cur_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        id_reg   <= id_next;
        prio_reg <= prio_next;
        sel_reg  <= sel_next;
        sw_reg   <= sw_next;
        ovf_reg  <= ovf_next;
        if (rsp_load)
        begin
            rsp_task_reg <= cur_valid_reg ? pbts_pkg::PORT_ID_W'(cur_id_reg) : '0;
            rsp_run_reg  <= cur_valid_reg;
            rsp_sw_reg   <= sw_reg;
            rsp_ovf_reg  <= ovf_reg;
            rsp_mask_reg <= ready;
        end
    end

    assign rsp_valid      = rsp_valid_reg;
    assign running_task   = rsp_task_reg;
    assign running_valid  = rsp_run_reg;
    assign switched       = rsp_sw_reg;
    assign queue_overflow = rsp_ovf_reg;
    assign ready_mask     = rsp_mask_reg;

    `PBTS_ASSERT_SAME(a_switch_runs, rsp_valid_reg && rsp_sw_reg, rsp_run_reg)
    `PBTS_ASSERT_SAME(a_pop_nonempty, qcmd.op == pbts_pkg::QOP_POP, !qstat.empty)
    `PBTS_ASSERT_NEXT(a_push_marks_ready, (qcmd.op == pbts_pkg::QOP_PUSH) && !qstat.full,
                      ready != '0)
    `PBTS_ASSERT_SAME(a_ovf_only_enq, (state_reg == pbts_pkg::ST_DONE) && ovf_reg,
                      kind_reg != pbts_pkg::KIND_SLEEP)

endmodule

`default_nettype wire

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// Priority bitmap task scheduler testbench
// Runs a table of directed commands and then random add, schedule, yield and
// sleep traffic. Both handshakes pause at random. Each result is compared field
// by field with its fixed table entry where one is given, else with a scoreboard
// model of the per-level FIFOs, the ready bitmap and the running task.
// ----------------------------------------------------------------------------
module tb;

    import pbts_pkg::*;

    localparam int LEVELS = 32;
    localparam int LEVEL_DEPTH = 8;
    localparam int RANDOM_ITEMS = 400;
    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 12;

    typedef struct packed {
        logic [PORT_ID_W-1:0] run_task;
        logic                 run_valid;
        logic                 did_switch;
        logic                 dropped;
        logic [MASK_W-1:0]    mask;
    } sched_result_t;

    typedef struct {
        kind_t                k;
        logic [PORT_ID_W-1:0] id;
        logic [PRIO_W-1:0]    prio;
        bit                   fixed;
        sched_result_t        res;
    } plan_row_t;

    localparam sched_result_t BLANK = '0;
    localparam int PLAN_LEN = 24;

    // after reset, extremes of id and priority, full-queue drops
    plan_row_t plan [PLAN_LEN] = '{
        '{KIND_SCHED, 8'h00, 5'd0,  1'b1, '{8'h00, 1'b0, 1'b0, 1'b0, 32'h0000_0000}},
        '{KIND_YIELD, 8'h00, 5'd0,  1'b1, '{8'h00, 1'b0, 1'b0, 1'b0, 32'h0000_0000}},
        '{KIND_SLEEP, 8'hFF, 5'd31, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0, 32'h0000_0000}},
        '{KIND_ADD,   8'hFF, 5'd0,  1'b1, '{8'h00, 1'b0, 1'b0, 1'b0, 32'h8000_0000}},
        '{KIND_ADD,   8'h00, 5'd31, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0, 32'h8000_0001}},
        '{KIND_SCHED, 8'h00, 5'd0,  1'b1, '{8'hFF, 1'b1, 1'b1, 1'b0, 32'h0000_0001}},
        '{KIND_SCHED, 8'h00, 5'd0,  1'b1, '{8'h00, 1'b1, 1'b1, 1'b0, 32'h8000_0000}},
        '{KIND_YIELD, 8'h00, 5'd0,  1'b1, '{8'h00, 1'b0, 1'b0, 1'b0, 32'h8000_0001}},
        '{KIND_SCHED, 8'h00, 5'd0,  1'b0, BLANK},
        '{KIND_SLEEP, 8'h00, 5'd0,  1'b0, BLANK},
        '{KIND_ADD,   8'h10, 5'd5,  1'b0, BLANK},
        '{KIND_ADD,   8'h11, 5'd5,  1'b0, BLANK},
        '{KIND_ADD,   8'h12, 5'd5,  1'b0, BLANK},
        '{KIND_ADD,   8'h13, 5'd5,  1'b0, BLANK},
        '{KIND_ADD,   8'h14, 5'd5,  1'b0, BLANK},
        '{KIND_ADD,   8'h15, 5'd5,  1'b0, BLANK},
        '{KIND_ADD,   8'h16, 5'd5,  1'b0, BLANK},
        '{KIND_ADD,   8'h17, 5'd5,  1'b0, BLANK},
        '{KIND_ADD,   8'hAA, 5'd5,  1'b1, '{8'h00, 1'b0, 1'b0, 1'b1, 32'h0400_0001}},
        '{KIND_SCHED, 8'h00, 5'd0,  1'b0, BLANK},
        '{KIND_ADD,   8'h55, 5'd5,  1'b0, BLANK},
        '{KIND_ADD,   8'h22, 5'd2,  1'b0, BLANK},
        '{KIND_SCHED, 8'h00, 5'd0,  1'b0, BLANK},
        '{KIND_YIELD, 8'h00, 5'd0,  1'b0, BLANK}
    };

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 req_valid = 1'b0;
    logic                 req_stall;
    logic [1:0]           kind = 2'd0;
    logic [PORT_ID_W-1:0] task_id = '0;
    logic [PRIO_W-1:0]    task_priority = '0;
    logic                 rsp_valid;
    logic                 rsp_stall = 1'b0;
    logic [PORT_ID_W-1:0] running_task;
    logic                 running_valid;
    logic                 switched;
    logic                 queue_overflow;
    logic [MASK_W-1:0]    ready_mask;

    logic [PORT_ID_W-1:0] lvl_slot [LEVELS][LEVEL_DEPTH];
    logic [2:0]           lvl_head [LEVELS];
    logic [3:0]           lvl_fill [LEVELS];
    logic [MASK_W-1:0]    ready_word = '0;
    logic [PORT_ID_W-1:0] run_id = '0;
    logic [PRIO_W-1:0]    run_prio = '0;
    logic                 run_on = 1'b0;

    sched_result_t pending [$];
    int            fails = 0;
    int            idle_cycles = 0;
    bit            calm = 1'b0;

    priority_bitmap_task_scheduler uut (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int draw_wait();
        return calm ? 0 : int'($urandom_range(0, 10));
    endfunction

    function automatic bit push_level(input logic [PRIO_W-1:0] p,
                                      input logic [PORT_ID_W-1:0] id);
        logic [2:0] slot;
        if (lvl_fill[p] == 4'(LEVEL_DEPTH))
            return 1'b1;
        slot = lvl_head[p] + lvl_fill[p][2:0];
        lvl_slot[p][slot] = id;
        lvl_fill[p] = lvl_fill[p] + 4'd1;
        ready_word[31 - p] = 1'b1;
        return 1'b0;
    endfunction

    function automatic sched_result_t predict_step(input kind_t k,
                                                   input logic [PORT_ID_W-1:0] id,
                                                   input logic [PRIO_W-1:0] p);
        sched_result_t r;
        logic [PRIO_W-1:0] top;
        logic [PORT_ID_W-1:0] popped;
        r = '0;
        top = '0;
        case (k)
            KIND_ADD:
                r.dropped = push_level(p, id);
            KIND_SCHED:
                if (ready_word != '0)
                begin
                    // highest set bit gives the lowest-numbered ready level
                    for (int b = 0; b < 32; b++)
                        if (ready_word[b])
                            top = 5'(31 - b);
                    popped = lvl_slot[top][lvl_head[top]];
                    lvl_head[top] = lvl_head[top] + 3'd1;
                    lvl_fill[top] = lvl_fill[top] - 4'd1;
                    if (lvl_fill[top] == 4'd0)
                        ready_word[31 - top] = 1'b0;
                    if (run_on)
                        r.dropped = push_level(run_prio, run_id);
                    run_id = popped;
                    run_prio = top;
                    run_on = 1'b1;
                    r.did_switch = 1'b1;
                end
            KIND_YIELD:
                if (run_on)
                begin
                    r.dropped = push_level(run_prio, run_id);
                    run_on = 1'b0;
                end
            default:
                run_on = 1'b0;
        endcase
        r.run_task = run_on ? run_id : '0;
        r.run_valid = run_on;
        r.mask = ready_word;
        return r;
    endfunction

    task automatic send_cmd(input kind_t k, input logic [PORT_ID_W-1:0] id,
                            input logic [PRIO_W-1:0] p, input bit fixed,
                            input sched_result_t given);
        int n;
        sched_result_t r;
        n = draw_wait();
        if (n > 0)
        begin
            req_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        req_valid <= 1'b1;
        kind <= k;
        task_id <= id;
        task_priority <= p;
        do @(posedge clk); while (req_stall !== 1'b0);
        r = predict_step(k, id, p);
        pending.push_back(fixed ? given : r);
    endtask

    initial
    begin : stimulus
        int add_pct;
        int roll;
        kind_t k;
        logic [PRIO_W-1:0] pr;
        for (int i = 0; i < LEVELS; i++)
        begin
            lvl_head[i] = '0;
            lvl_fill[i] = '0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < PLAN_LEN; i++)
            send_cmd(plan[i].k, plan[i].id, plan[i].prio, plan[i].fixed, plan[i].res);
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            calm = ((n / 40) % 4 == 3);
            add_pct = ((n / 50) % 2 == 0) ? 45 : 25;
            roll = $urandom_range(0, 99);
            k = (roll < add_pct) ? KIND_ADD :
                (roll < add_pct + 35) ? KIND_SCHED :
                (roll < add_pct + 50) ? KIND_YIELD : KIND_SLEEP;
            // half the adds land on a few hot levels so queues fill up
            if ($urandom_range(0, 1) == 0)
                pr = 5'($urandom_range(0, 31));
            else
                pr = {($urandom_range(0, 1) == 0) ? 3'b000 : 3'b111, 2'($urandom)};
            send_cmd(k, 8'($urandom), pr, 1'b0, BLANK);
        end
        req_valid <= 1'b0;
        while (pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fails == 0)
            $display("priority_bitmap_task_scheduler: match");
        else
            $display("priority_bitmap_task_scheduler: mismatch");
        $finish;
    end

    initial
    begin : rsp_side
        int n;
        forever
        begin
            n = draw_wait();
            if (n > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            do @(posedge clk); while (!(rsp_valid === 1'b1 && rsp_stall == 1'b0));
        end
    end

    always @(posedge clk)
    begin : result_check
        sched_result_t want;
        if (rst_n && rsp_valid === 1'b1 && !rsp_stall)
        begin
            if (pending.size() == 0)
            begin
                $error("result with nothing expected");
                fails++;
            end
            else
            begin
                want = pending.pop_front();
                if (running_task !== want.run_task)
                begin
                    $error("running_task: expected %0h, actual %0h", want.run_task, running_task);
                    fails++;
                end
                if (running_valid !== want.run_valid)
                begin
                    $error("running_valid: expected %0b, actual %0b",
                           want.run_valid, running_valid);
                    fails++;
                end
                if (switched !== want.did_switch)
                begin
                    $error("switched: expected %0b, actual %0b", want.did_switch, switched);
                    fails++;
                end
                if (queue_overflow !== want.dropped)
                begin
                    $error("queue_overflow: expected %0b, actual %0b",
                           want.dropped, queue_overflow);
                    fails++;
                end
                if (ready_mask !== want.mask)
                begin
                    $error("ready_mask: expected %08h, actual %08h", want.mask, ready_mask);
                    fails++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == IDLE_LIMIT)
        begin
            $display("priority_bitmap_task_scheduler: mismatch");
            $finish;
        end
    end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/pbts_pkg.sv
rtl/core/pbts_qptr.sv
rtl/core/pbts_queues.sv
rtl/core/priority_bitmap_task_scheduler.sv
dv/tb.sv
